[rtl/phfe_pkg.sv]
// Package: shared types, field codes and phase codes for the header field extractor.
`default_nettype none
package phfe_pkg;
    localparam int MAX_TAGS_DEF = 4;
    localparam int ECHO_BYTES_DEF = 48;
    localparam int HDR_DEPTH = 28;
    localparam int QDEPTH = 4;

    localparam logic [4:0] C_ETH_DST = 5'd0;
    localparam logic [4:0] C_ETH_SRC = 5'd1;
    localparam logic [4:0] C_ETH_TYPE = 5'd2;
    localparam logic [4:0] C_VLAN_VID = 5'd3;
    localparam logic [4:0] C_VLAN_PCP = 5'd4;
    localparam logic [4:0] C_VLAN_TYPE = 5'd5;
    localparam logic [4:0] C_MPLS_LABEL = 5'd6;
    localparam logic [4:0] C_MPLS_TC = 5'd7;
    localparam logic [4:0] C_MPLS_BOS = 5'd8;
    localparam logic [4:0] C_ARP_OP = 5'd9;
    localparam logic [4:0] C_ARP_SHA = 5'd10;
    localparam logic [4:0] C_ARP_SPA = 5'd11;
    localparam logic [4:0] C_ARP_THA = 5'd12;
    localparam logic [4:0] C_ARP_TPA = 5'd13;
    localparam logic [4:0] C_IP_SRC = 5'd14;
    localparam logic [4:0] C_IP_DST = 5'd15;
    localparam logic [4:0] C_IP_PROTO = 5'd16;
    localparam logic [4:0] C_IP_DSCP = 5'd17;
    localparam logic [4:0] C_IP_ECN = 5'd18;
    localparam logic [4:0] C_ICMP_TYPE = 5'd19;
    localparam logic [4:0] C_ICMP_CODE = 5'd20;
    localparam logic [4:0] C_ECHO_ID = 5'd21;
    localparam logic [4:0] C_ECHO_SEQ = 5'd22;
    localparam logic [4:0] C_ECHO_WORD = 5'd23;
    localparam logic [4:0] C_DONE = 5'd24;

    localparam logic [2:0] PH_ETH = 3'd0;
    localparam logic [2:0] PH_VLAN = 3'd1;
    localparam logic [2:0] PH_MPLS = 3'd2;
    localparam logic [2:0] PH_ARP = 3'd3;
    localparam logic [2:0] PH_IPV4 = 3'd4;
    localparam logic [2:0] PH_ICMP = 3'd5;
    localparam logic [2:0] PH_ECHO = 3'd6;

    // event classes handed from front to back
    localparam logic [2:0] EV_ETH = 3'd0;
    localparam logic [2:0] EV_VLAN = 3'd1;
    localparam logic [2:0] EV_MPLS = 3'd2;
    localparam logic [2:0] EV_ARP = 3'd3;
    localparam logic [2:0] EV_IPV4 = 3'd4;
    localparam logic [2:0] EV_ICMP = 3'd5;
    localparam logic [2:0] EV_ECHO_HDR = 3'd6;
    localparam logic [2:0] EV_ECHO_WORD = 3'd7;

    typedef struct packed {
        logic        has_ev;
        logic [2:0]  ev;
        logic [2:0]  idx;
        logic [2:0]  wlen;
        logic        done;
        logic [3:0]  tags;
        logic [223:0] hdr;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [2:0]  item_index;
        logic [63:0] field_value;
        logic        last_of_packet;
    } res_t;
endpackage
`default_nettype wire

[rtl/phfe_if.sv]
// Interfaces: input byte channel and result channel.
`default_nettype none
interface phfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;
    modport source (output valid, data_byte, end_of_packet, input ready);
    modport sink (input valid, data_byte, end_of_packet, output ready);
endinterface

interface phfe_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_code;
    logic [2:0]  item_index;
    logic [63:0] field_value;
    logic        last_of_packet;
    modport source (output valid, field_code, item_index, field_value, last_of_packet,
                    input ready);
    modport sink (input valid, field_code, item_index, field_value, last_of_packet,
                  output ready);
endinterface
`default_nettype wire

[rtl/phfe_front.sv]
// Front end: tracks offsets and phases, captures header bytes, issues commands.
`default_nettype none
module phfe_front #(
    parameter int MAX_TAGS = phfe_pkg::MAX_TAGS_DEF,
    parameter int ECHO_BYTES = phfe_pkg::ECHO_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_packet,
    output logic               cmd_valid,
    output phfe_pkg::cmd_t     cmd,
    input  wire logic          cmd_ready
);
    import phfe_pkg::*;

    logic [7:0]   off_reg, off_next;
    logic [7:0]   idx_reg, idx_next;
    logic [2:0]   phase_reg, phase_next;
    logic [3:0]   tags_reg, tags_next;
    logic         stop_reg, stop_next;
    logic [7:0]   hdr_reg [HDR_DEPTH];
    logic [223:0] hflat;
    logic [15:0]  et;
    logic         fire, live, wr;
    logic [4:0]   wpos;
    logic [6:0]   d;

    assign in_ready = cmd_ready;
    assign fire = in_valid && in_ready;
    assign live = !stop_reg && (off_reg != 8'hff);
    assign d = idx_reg[6:0] - 7'd4;

    always_comb
    begin
        for (int i = 0; i < HDR_DEPTH; i++)
        begin
            hflat[(HDR_DEPTH-1-i)*8 +: 8] = hdr_reg[i];
        end
        wr = 1'b0;
        wpos = idx_reg[4:0];
        if (phase_reg == PH_ECHO)
        begin
            wr = 1'b1;
            if (idx_reg >= 8'd4)
            begin
                wpos = 5'd4 + {2'b0, d[2:0]};
            end
        end
        else if (idx_reg < 8'(HDR_DEPTH))
        begin
            wr = 1'b1;
        end
        cmd = '0;
        cmd.hdr = hflat;
        if (wr)
        begin
            cmd.hdr[(HDR_DEPTH-1-int'(wpos))*8 +: 8] = data_byte;
        end
        et = (phase_reg == PH_ETH) ? cmd.hdr[223-96 -: 16] : cmd.hdr[223-16 -: 16];
        off_next = (off_reg != 8'hff) ? off_reg + 8'd1 : off_reg;
        idx_next = idx_reg + 8'd1;
        phase_next = phase_reg;
        tags_next = tags_reg;
        stop_next = stop_reg;
        cmd.idx = 3'd0;
        if (live)
        begin
            if (!wr)
            begin
                stop_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ETH, PH_VLAN:
                    begin
                        if ((phase_reg == PH_ETH && idx_reg == 8'd13) ||
                            (phase_reg == PH_VLAN && idx_reg == 8'd3))
                        begin
                            cmd.has_ev = 1'b1;
                            cmd.ev = (phase_reg == PH_ETH) ? EV_ETH : EV_VLAN;
                            cmd.idx = tags_reg[2:0];
                            if (phase_reg == PH_VLAN)
                            begin
                                tags_next = tags_reg + 4'd1;
                            end
                            idx_next = 8'd0;
                            if (et == 16'h8100 || et == 16'h88a8)
                            begin
                                if (32'(tags_next) < 32'(MAX_TAGS))
                                begin
                                    phase_next = PH_VLAN;
                                end
                                else
                                begin
                                    stop_next = 1'b1;
                                end
                            end
                            else if (et == 16'h8847 || et == 16'h8848)
                            begin
                                phase_next = PH_MPLS;
                            end
                            else if (et == 16'h0806)
                            begin
                                phase_next = PH_ARP;
                            end
                            else if (et == 16'h0800)
                            begin
                                phase_next = PH_IPV4;
                            end
                            else
                            begin
                                stop_next = 1'b1;
                            end
                        end
                    end
                    PH_MPLS:
                    begin
                        if (idx_reg == 8'd3)
                        begin
                            cmd.has_ev = 1'b1;
                            cmd.ev = EV_MPLS;
                            stop_next = 1'b1;
                        end
                    end
                    PH_ARP:
                    begin
                        if (idx_reg == 8'd27)
                        begin
                            cmd.has_ev = 1'b1;
                            cmd.ev = EV_ARP;
                            stop_next = 1'b1;
                        end
                    end
                    PH_IPV4:
                    begin
                        if (idx_reg == 8'd19)
                        begin
                            cmd.has_ev = 1'b1;
                            cmd.ev = EV_IPV4;
                            idx_next = 8'd0;
                            if (cmd.hdr[223-50 -: 14] != 14'd0 || cmd.hdr[223-72 -: 8] != 8'd1)
                            begin
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_ICMP;
                            end
                        end
                    end
                    PH_ICMP:
                    begin
                        if (idx_reg == 8'd3)
                        begin
                            cmd.has_ev = 1'b1;
                            cmd.ev = EV_ICMP;
                            idx_next = 8'd0;
                            if (cmd.hdr[223 -: 8] == 8'd8 || cmd.hdr[223 -: 8] == 8'd0)
                            begin
                                phase_next = PH_ECHO;
                            end
                            else
                            begin
                                stop_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (idx_reg < 8'd4)
                        begin
                            if (idx_reg == 8'd3)
                            begin
                                cmd.has_ev = 1'b1;
                                cmd.ev = EV_ECHO_HDR;
                            end
                        end
                        else
                        begin
                            if (d[2:0] == 3'd7 || 32'(d) + 1 == ECHO_BYTES)
                            begin
                                cmd.has_ev = 1'b1;
                                cmd.ev = EV_ECHO_WORD;
                                cmd.idx = d[5:3];
                                cmd.wlen = d[2:0];
                            end
                            if (32'(d) + 1 >= ECHO_BYTES)
                            begin
                                stop_next = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
        cmd.tags = tags_next;
        cmd.done = end_of_packet;
        if (end_of_packet)
        begin
            off_next = 8'd0;
            idx_next = 8'd0;
            phase_next = PH_ETH;
            tags_next = 4'd0;
            stop_next = 1'b0;
        end
    end

    assign cmd_valid = fire && (cmd.has_ev || cmd.done);

    always_ff @(posedge clk)
    begin
        if (fire && live && wr)
        begin
            hdr_reg[wpos] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            idx_reg <= '0;
            phase_reg <= PH_ETH;
            tags_reg <= '0;
            stop_reg <= 1'b0;
        end
        else if (fire)
        begin
            off_reg <= off_next;
            idx_reg <= live ? idx_next : idx_reg;
            phase_reg <= live ? phase_next : phase_reg;
            tags_reg <= live ? tags_next : tags_reg;
            stop_reg <= stop_next;
            if (end_of_packet)
            begin
                idx_reg <= '0;
                phase_reg <= PH_ETH;
                tags_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/phfe_queue.sv]
// Command queue between front and back ends.
`default_nettype none
module phfe_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_valid,
    input  wire phfe_pkg::cmd_t wr_data,
    output logic             wr_ready,
    output logic             rd_valid,
    output phfe_pkg::cmd_t   rd_data,
    input  wire logic        rd_ready
);
    import phfe_pkg::*;
    localparam int AW = $clog2(QDEPTH);

    cmd_t         mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign wr_ready = (cnt_reg != (AW+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[rtl/phfe_back.sv]
// Back end: expands each command into its result items, one per cycle while the output is not stalled.
`default_nettype none
module phfe_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    input  wire phfe_pkg::cmd_t cmd,
    output logic             cmd_ready,
    phfe_out_if.source       res
);
    import phfe_pkg::*;

    logic [2:0]  step_reg, step_next;
    res_t        cur;
    logic        have, last_step;
    logic        ov_reg;
    res_t        ob_reg;
    logic        take;
    logic [15:0] op;
    logic        arp_ok, arp_addr;
    logic [63:0] word;
    logic [223:0] h;

    assign h = cmd.hdr;
    assign take = !ov_reg || res.ready;
    assign op = h[223-48 -: 16];
    assign arp_ok = h[223 -: 16] == 16'd1 && h[207 -: 16] == 16'h0800 &&
                    h[191 -: 8] == 8'd6 && h[183 -: 8] == 8'd4;
    assign arp_addr = op == 16'd1 || op == 16'd2;

    always_comb
    begin
        word = h[223-32 -: 64] >> (8 * (7 - int'(cmd.wlen)));
        cur = '0;
        have = 1'b0;
        last_step = 1'b1;
        step_next = step_reg + 3'd1;
        if (!cmd.has_ev)
        begin
            have = 1'b1;
            cur.field_code = C_DONE;
            cur.field_value = 64'(cmd.tags);
            cur.last_of_packet = 1'b1;
        end
        else
        begin
            unique case (cmd.ev)
                EV_ETH:
                begin
                    have = 1'b1;
                    last_step = step_reg == 3'd2;
                    unique case (step_reg)
                        3'd0: begin cur.field_code = C_ETH_DST;
                            cur.field_value = 64'(h[223 -: 48]); end
                        3'd1: begin cur.field_code = C_ETH_SRC;
                            cur.field_value = 64'(h[175 -: 48]); end
                        default: begin cur.field_code = C_ETH_TYPE;
                            cur.field_value = 64'(h[127 -: 16]); end
                    endcase
                end
                EV_VLAN:
                begin
                    have = 1'b1;
                    cur.item_index = cmd.idx;
                    last_step = step_reg == 3'd2;
                    unique case (step_reg)
                        3'd0: begin cur.field_code = C_VLAN_VID;
                            cur.field_value = 64'(h[219 -: 12]); end
                        3'd1: begin cur.field_code = C_VLAN_PCP;
                            cur.field_value = 64'(h[223 -: 3]); end
                        default: begin cur.field_code = C_VLAN_TYPE;
                            cur.field_value = 64'(h[207 -: 16]); end
                    endcase
                end
                EV_MPLS:
                begin
                    have = 1'b1;
                    last_step = step_reg == 3'd2;
                    unique case (step_reg)
                        3'd0: begin cur.field_code = C_MPLS_LABEL;
                            cur.field_value = 64'(h[223 -: 20]); end
                        3'd1: begin cur.field_code = C_MPLS_TC;
                            cur.field_value = 64'(h[203 -: 3]); end
                        default: begin cur.field_code = C_MPLS_BOS;
                            cur.field_value = 64'(h[200]); end
                    endcase
                end
                EV_ARP:
                begin
                    last_step = !arp_ok || !arp_addr || step_reg == 3'd4;
                    have = arp_ok && (step_reg != 3'd0 || op <= 16'hff);
                    unique case (step_reg)
                        3'd0: begin cur.field_code = C_ARP_OP;
                            cur.field_value = 64'(op); end
                        3'd1: begin cur.field_code = C_ARP_SHA;
                            cur.field_value = 64'(h[159 -: 48]); end
                        3'd2: begin cur.field_code = C_ARP_SPA;
                            cur.field_value = 64'(h[111 -: 32]); end
                        3'd3: begin cur.field_code = C_ARP_THA;
                            cur.field_value = 64'(h[79 -: 48]); end
                        default: begin cur.field_code = C_ARP_TPA;
                            cur.field_value = 64'(h[31 -: 32]); end
                    endcase
                end
                EV_IPV4:
                begin
                    have = 1'b1;
                    last_step = step_reg == 3'd4;
                    unique case (step_reg)
                        3'd0: begin cur.field_code = C_IP_DSCP;
                            cur.field_value = 64'(h[215 -: 6]); end
                        3'd1: begin cur.field_code = C_IP_ECN;
                            cur.field_value = 64'(h[209 -: 2]); end
                        3'd2: begin cur.field_code = C_IP_PROTO;
                            cur.field_value = 64'(h[151 -: 8]); end
                        3'd3: begin cur.field_code = C_IP_SRC;
                            cur.field_value = 64'(h[127 -: 32]); end
                        default: begin cur.field_code = C_IP_DST;
                            cur.field_value = 64'(h[95 -: 32]); end
                    endcase
                end
                EV_ICMP, EV_ECHO_HDR:
                begin
                    have = 1'b1;
                    last_step = step_reg == 3'd1;
                    if (cmd.ev == EV_ICMP)
                    begin
                        cur.field_code = (step_reg == 3'd0) ? C_ICMP_TYPE : C_ICMP_CODE;
                        cur.field_value = 64'((step_reg == 3'd0) ? h[223 -: 8] : h[215 -: 8]);
                    end
                    else
                    begin
                        cur.field_code = (step_reg == 3'd0) ? C_ECHO_ID : C_ECHO_SEQ;
                        cur.field_value = 64'((step_reg == 3'd0) ? h[223 -: 16] : h[207 -: 16]);
                    end
                end
                default:
                begin
                    have = 1'b1;
                    cur.field_code = C_ECHO_WORD;
                    cur.item_index = cmd.idx;
                    cur.field_value = word;
                end
            endcase
            if (cmd.done)
            begin
                if (step_reg == 3'd7)
                begin
                    have = 1'b1;
                    cur = '0;
                    cur.field_code = C_DONE;
                    cur.field_value = 64'(cmd.tags);
                    cur.last_of_packet = 1'b1;
                    last_step = 1'b1;
                end
                else if (last_step)
                begin
                    step_next = 3'd7;
                    last_step = 1'b0;
                end
            end
        end
        if (last_step)
        begin
            step_next = 3'd0;
        end
    end

    assign cmd_ready = take && last_step;

    always_ff @(posedge clk)
    begin
        if (cmd_valid && take && have)
        begin
            ob_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ov_reg <= cmd_valid && have;
                if (cmd_valid)
                begin
                    step_reg <= step_next;
                end
            end
        end
    end

    assign res.valid = ov_reg;
    assign res.field_code = ob_reg.field_code;
    assign res.item_index = ob_reg.item_index;
    assign res.field_value = ob_reg.field_value;
    assign res.last_of_packet = ob_reg.last_of_packet;
endmodule
`default_nettype wire

[rtl/packet_header_field_extractor.sv]
// Top level: packet header field extractor.
// Channel   Dir  Payload
// in        in   data_byte[7:0], end_of_packet
// out       out  field_code[4:0], item_index[2:0], field_value[63:0], last_of_packet
// One byte is taken per cycle while the command queue has room.
// A header-completing byte queues one command; the back end emits one result per cycle while the
// output is not stalled, so a command yields up to six results, behind a one-entry output register.
// Reset clears phase, offsets, queue and output valid; header capture is not cleared.
// A stalled output holds the back end; the front stalls only when the queue is full.
`default_nettype none
module packet_header_field_extractor #(
    parameter int MAX_TAGS = phfe_pkg::MAX_TAGS_DEF,
    parameter int ECHO_DATA_BYTES = phfe_pkg::ECHO_BYTES_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    phfe_in_if.sink    in,
    phfe_out_if.source out
);
    import phfe_pkg::*;

    logic cv, cr, qv, qr;
    cmd_t c, qc;

    phfe_front #(.MAX_TAGS(MAX_TAGS), .ECHO_BYTES(ECHO_DATA_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
        .data_byte(in.data_byte), .end_of_packet(in.end_of_packet),
        .cmd_valid(cv), .cmd(c), .cmd_ready(cr)
    );

    phfe_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(cv), .wr_data(c), .wr_ready(cr),
        .rd_valid(qv), .rd_data(qc), .rd_ready(qr)
    );

    phfe_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(qv), .cmd(qc), .cmd_ready(qr), .res(out)
    );
endmodule
`default_nettype wire
